@@ design/hdlcenc_pkg.sv @@
// Package for the HDLC frame encoder: opcodes, queue entry type, line constants
// and the bytewise reflected CCITT CRC fold. No dependencies.
package hdlcenc_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
  localparam logic [7:0]  ESC_BYTE   = 8'h7D;
  localparam logic [7:0]  ESC_XOR    = 8'h20;
  localparam logic [15:0] CRC_PRESET = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_DATA   = 2'd1,
    OP_END    = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_BEGIN = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    SLOT_B0   = 3'b001,
    SLOT_B1   = 3'b010,
    SLOT_FLAG = 3'b100
  } slot_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] b0;
    logic [7:0] b1;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } qport_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0]  t;
    logic [15:0] r;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    r = {t, crc[15:8]};
    r = r ^ {12'h000, t[7:4]};
    r = r ^ {5'b00000, t, 3'b000};
    return r;
  endfunction

endpackage

@@ design/hdlcenc_front.sv @@
// Front end: accepts input beats, updates the running CRC and classifies each
// beat into a queue entry (unused opcodes push nothing). Depends on hdlcenc_pkg.
module hdlcenc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            opcode,
  input  logic [7:0]            data_byte,
  input  logic                  q_full,
  output hdlcenc_pkg::qport_t   push
);

  logic [15:0] crc;
  logic [15:0] crc_next;
  logic [15:0] crc_lo;
  logic        accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign crc_lo   = hdlcenc_pkg::crc_fold(crc, crc[7:0]);

  always_comb begin
    crc_next         = crc;
    push.valid       = 1'b0;
    push.entry.kind  = hdlcenc_pkg::KIND_BEGIN;
    push.entry.b0    = data_byte;
    push.entry.b1    = crc[15:8];
    unique case (hdlcenc_pkg::opcode_t'(opcode))
      hdlcenc_pkg::OP_BEGIN: begin
        crc_next   = hdlcenc_pkg::CRC_PRESET;
        push.valid = accept;
      end
      hdlcenc_pkg::OP_DATA: begin
        crc_next        = hdlcenc_pkg::crc_fold(crc, data_byte);
        push.valid      = accept;
        push.entry.kind = hdlcenc_pkg::KIND_DATA;
      end
      hdlcenc_pkg::OP_END: begin
        crc_next        = hdlcenc_pkg::crc_fold(crc_lo, crc[15:8]);
        push.valid      = accept;
        push.entry.kind = hdlcenc_pkg::KIND_END;
        push.entry.b0   = crc[7:0];
      end
      default: begin
        crc_next = crc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= hdlcenc_pkg::CRC_PRESET;
    end else if (accept) begin
      crc <= crc_next;
    end
  end

endmodule

@@ design/hdlcenc_queue.sv @@
// Short FIFO of classified entries between front and back end.
// Depends on hdlcenc_pkg.
module hdlcenc_queue #(
  parameter int unsigned DEPTH = hdlcenc_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  hdlcenc_pkg::qport_t push,
  output logic                full,
  input  logic                pop,
  output hdlcenc_pkg::qport_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  hdlcenc_pkg::entry_t store [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                do_push;
  logic                do_pop;

  assign full       = (count == CNT_FULL);
  assign head.valid = (count != '0);
  assign head.entry = store[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/hdlcenc_back.sv @@
// Back end: expands queue entries into stuffed line bytes, one per cycle unless
// the output is stalled, into an output register. Depends on hdlcenc_pkg.
module hdlcenc_back (
  input  logic                clk,
  input  logic                rst,
  input  hdlcenc_pkg::qport_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                last_of_run
);

  logic                busy;
  hdlcenc_pkg::kind_t  kind;
  logic [7:0]          b0;
  logic [7:0]          b1;
  hdlcenc_pkg::slot_t  slot;
  logic                esc;

  logic                advance;
  logic                done;
  logic [7:0]          cur;
  logic                special;
  logic [7:0]          emit_byte;
  logic                emit_last;
  hdlcenc_pkg::slot_t  slot_next;
  logic                esc_next;

  assign advance = busy && (!out_valid || !out_stall);
  assign cur     = (slot == hdlcenc_pkg::SLOT_B1) ? b1 : b0;
  assign special = (cur == hdlcenc_pkg::FLAG_BYTE) || (cur == hdlcenc_pkg::ESC_BYTE);
  assign pop     = head.valid && (!busy || (advance && done));

  always_comb begin
    emit_byte = hdlcenc_pkg::FLAG_BYTE;
    emit_last = 1'b1;
    done      = 1'b1;
    slot_next = slot;
    esc_next  = 1'b0;
    unique case (slot) inside
      hdlcenc_pkg::SLOT_B0, hdlcenc_pkg::SLOT_B1: begin
        if (special && !esc) begin
          emit_byte = hdlcenc_pkg::ESC_BYTE;
          emit_last = 1'b0;
          done      = 1'b0;
          esc_next  = 1'b1;
        end else begin
          emit_byte = esc ? (cur ^ hdlcenc_pkg::ESC_XOR) : cur;
          emit_last = (kind == hdlcenc_pkg::KIND_DATA);
          done      = (kind == hdlcenc_pkg::KIND_DATA);
          slot_next = (slot == hdlcenc_pkg::SLOT_B0) ? hdlcenc_pkg::SLOT_B1
                                                      : hdlcenc_pkg::SLOT_FLAG;
        end
      end
      default: begin
        emit_byte = hdlcenc_pkg::FLAG_BYTE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind <= head.entry.kind;
      b0   <= head.entry.b0;
      b1   <= head.entry.b1;
      slot <= (head.entry.kind == hdlcenc_pkg::KIND_BEGIN) ? hdlcenc_pkg::SLOT_FLAG
                                                           : hdlcenc_pkg::SLOT_B0;
      esc  <= 1'b0;
    end else if (advance) begin
      slot <= slot_next;
      esc  <= esc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte    <= emit_byte;
      last_of_run <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (advance && done) begin
        busy <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ design/hdlc_frame_encoder_crc16_unit.sv @@
// HDLC frame encoder with byte stuffing and reflected CCITT CRC-16.
// The first line byte of an input beat passes the queue, the back-end entry
// registers and the output register. The back end emits one line byte per cycle
// unless the output is stalled; an input beat yields up to five line bytes.
// Reset: synchronous; clears queue and output valid, presets the CRC to 0xFFFF.
module hdlc_frame_encoder_crc16_unit #(
  parameter int unsigned QUEUE_DEPTH = hdlcenc_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] opcode,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last_of_run
);

  hdlcenc_pkg::qport_t push;
  hdlcenc_pkg::qport_t head;
  logic                q_full;
  logic                pop;

  hdlcenc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .data_byte (data_byte),
    .q_full    (q_full),
    .push      (push)
  );

  hdlcenc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .pop  (pop),
    .head (head)
  );

  hdlcenc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

@@ design/hdlcenc_checker.sv @@
// Port-level checks for the HDLC frame encoder, bound to the top level.
// Depends on hdlc_frame_encoder_crc16_unit.
module hdlcenc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] opcode,
  input logic [7:0] data_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       last_of_run
);

  logic out_beat;
  assign out_beat = out_valid && !out_stall;

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(opcode) && $stable(data_byte))
    else $error("stalled input beat changed");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last_of_run))
    else $error("stalled output beat changed");

  a_flag_last: assert property (@(posedge clk) disable iff (rst)
    out_beat && out_byte == 8'h7E |-> last_of_run)
    else $error("flag byte not at end of run");

  a_esc_not_last: assert property (@(posedge clk) disable iff (rst)
    out_beat && out_byte == 8'h7D |-> !last_of_run)
    else $error("escape byte ends a run");

endmodule

bind hdlc_frame_encoder_crc16_unit hdlcenc_checker u_checker (.*);

@@ tb/sv/hdlc_frame_encoder_crc16_unit_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for hdlc_frame_encoder_crc16_unit: a queue-fed driver, a line
// byte monitor and a bitwise CRC-16 predictor compared beat by beat. Depends on hdlcenc_pkg.
module hdlc_frame_encoder_crc16_unit_test;

  localparam logic [15:0] CRC_POLY       = 16'h8408;
  localparam logic [15:0] CRC_PRESET     = hdlcenc_pkg::CRC_PRESET;
  localparam logic [7:0]  FLAG_BYTE      = hdlcenc_pkg::FLAG_BYTE;
  localparam logic [7:0]  ESC_BYTE       = hdlcenc_pkg::ESC_BYTE;
  localparam logic [7:0]  ESC_XOR        = hdlcenc_pkg::ESC_XOR;
  localparam int          RANDOM_BEATS   = 500;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          DRAIN_CYCLES   = 20;

  typedef struct {
    hdlcenc_pkg::opcode_t op;
    logic [7:0]           payload;
  } enc_beat_t;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } line_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] opcode = hdlcenc_pkg::OP_BEGIN;
  logic [7:0] data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       last_of_run;

  enc_beat_t  beat_backlog[$];
  line_byte_t line_forecast[$];
  logic [15:0] frame_crc = CRC_PRESET;

  int  total_beats = -1;
  int  counted_beats = 0;
  int  accepted_beats = 0;
  int  checked_bytes = 0;
  int  escaped_bytes = 0;
  int  frames_closed = 0;
  int  errors = 0;
  int  quiet_cycles = 0;
  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  in_took = 1'b0;
  bit  out_took = 1'b0;

  hdlc_frame_encoder_crc16_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  task automatic push_line(logic [7:0] v);
    line_forecast.push_back('{value: v, last: 1'b0});
  endtask

  task automatic stuff_line(logic [7:0] b);
    frame_crc = crc_step(frame_crc, b);
    if (b == FLAG_BYTE || b == ESC_BYTE) begin
      push_line(ESC_BYTE);
      push_line(b ^ ESC_XOR);
      escaped_bytes++;
    end else begin
      push_line(b);
    end
  endtask

  task automatic encode_beat(hdlcenc_pkg::opcode_t op, logic [7:0] b);
    logic [15:0] sent_crc;
    sent_crc = frame_crc;
    case (op)
      hdlcenc_pkg::OP_BEGIN: begin
        frame_crc = CRC_PRESET;
        push_line(FLAG_BYTE);
      end
      hdlcenc_pkg::OP_DATA: begin
        stuff_line(b);
      end
      hdlcenc_pkg::OP_END: begin
        stuff_line(sent_crc[7:0]);
        stuff_line(sent_crc[15:8]);
        push_line(FLAG_BYTE);
        frames_closed++;
      end
      default: ;
    endcase
    if (op != hdlcenc_pkg::OP_UNUSED) line_forecast[line_forecast.size() - 1].last = 1'b1;
  endtask

  task automatic add_beat(hdlcenc_pkg::opcode_t op, logic [7:0] b);
    beat_backlog.push_back('{op: op, payload: b});
    if (op != hdlcenc_pkg::OP_UNUSED) counted_beats++;
  endtask

  function automatic logic [7:0] pick_payload();
    int r;
    r = $urandom_range(7);
    if (r == 0) return FLAG_BYTE;
    if (r == 1) return ESC_BYTE;
    return 8'($urandom_range(255));
  endfunction

  // driver: hold a stalled beat, otherwise present the next one or idle
  always @(negedge clk) begin
    enc_beat_t cur;
    if (!rst) begin
      if (!in_valid || in_took) begin
        if (beat_backlog.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur = beat_backlog.pop_front();
          in_valid  <= 1'b1;
          opcode    <= cur.op;
          data_byte <= cur.payload;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // idling phases follow progress through the beat list
  always @(negedge clk) begin
    int phase;
    phase = (total_beats > 0) ? (accepted_beats * 4) / total_beats : 0;
    case (phase)
      1:       begin idle_pct = 74; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 74; end
      3:       begin idle_pct = 29; stall_pct = 29; end
      default: begin idle_pct = 0;  stall_pct = 0;  end
    endcase
  end

  // monitor: check line bytes, then predict for an accepted input beat
  always @(posedge clk) begin
    line_byte_t want;
    in_took  = !rst && in_valid && !in_stall;
    out_took = !rst && (out_valid === 1'b1) && !out_stall;
    if (out_took) begin
      if (line_forecast.size() == 0) begin
        $display("%0t: unexpected line byte %02h last %0b", $time, out_byte, last_of_run);
        errors++;
      end else begin
        want = line_forecast.pop_front();
        if (want.value !== out_byte || want.last !== last_of_run) begin
          $display("%0t: line byte mismatch: expected %02h last %0b, got %02h last %0b",
                   $time, want.value, want.last, out_byte, last_of_run);
          errors++;
        end
        checked_bytes++;
      end
    end
    if (in_took) begin
      encode_beat(hdlcenc_pkg::opcode_t'(opcode), data_byte);
      accepted_beats++;
    end
    quiet_cycles = (in_took || out_took) ? 0 : quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [15:0] c;
    bit          lo_hit;
    bit          hi_hit;
    int          n;
    int          goal;
    lo_hit = 1'b0;
    hi_hit = 1'b0;
    // data and end with no frame open, then an ignored opcode
    add_beat(hdlcenc_pkg::OP_DATA, 8'h7E);
    add_beat(hdlcenc_pkg::OP_END, 8'h00);
    add_beat(hdlcenc_pkg::OP_UNUSED, 8'hA5);
    add_beat(hdlcenc_pkg::OP_BEGIN, 8'hFF);
    add_beat(hdlcenc_pkg::OP_DATA, 8'h00);
    add_beat(hdlcenc_pkg::OP_DATA, 8'hFF);
    add_beat(hdlcenc_pkg::OP_DATA, 8'h7E);
    add_beat(hdlcenc_pkg::OP_DATA, 8'h7D);
    add_beat(hdlcenc_pkg::OP_DATA, 8'h5E);
    add_beat(hdlcenc_pkg::OP_DATA, 8'h5D);
    add_beat(hdlcenc_pkg::OP_UNUSED, 8'h5A);
    add_beat(hdlcenc_pkg::OP_DATA, 8'h20);
    add_beat(hdlcenc_pkg::OP_END, 8'hFF);
    // second end carries the CRC folded with the bytes just sent
    add_beat(hdlcenc_pkg::OP_END, 8'h55);
    add_beat(hdlcenc_pkg::OP_BEGIN, 8'h00);
    add_beat(hdlcenc_pkg::OP_END, 8'h00);
    // one-byte frames whose CRC bytes need escaping
    for (int b = 0; b < 256; b++) begin
      c = crc_step(CRC_PRESET, 8'(b));
      if ((!lo_hit && (c[7:0] == FLAG_BYTE || c[7:0] == ESC_BYTE)) ||
          (!hi_hit && (c[15:8] == FLAG_BYTE || c[15:8] == ESC_BYTE))) begin
        if (c[7:0] == FLAG_BYTE || c[7:0] == ESC_BYTE) lo_hit = 1'b1;
        if (c[15:8] == FLAG_BYTE || c[15:8] == ESC_BYTE) hi_hit = 1'b1;
        add_beat(hdlcenc_pkg::OP_BEGIN, 8'($urandom_range(255)));
        add_beat(hdlcenc_pkg::OP_DATA, 8'(b));
        add_beat(hdlcenc_pkg::OP_END, 8'($urandom_range(255)));
      end
    end
    goal = counted_beats + RANDOM_BEATS;
    while (counted_beats < goal) begin
      if ($urandom_range(99) < 85) begin
        add_beat(hdlcenc_pkg::OP_BEGIN, 8'($urandom_range(255)));
        n = ($urandom_range(9) == 0) ? $urandom_range(24) : $urandom_range(6);
        repeat (n) add_beat(hdlcenc_pkg::OP_DATA, pick_payload());
        if ($urandom_range(9) != 0) add_beat(hdlcenc_pkg::OP_END, 8'($urandom_range(255)));
      end else begin
        add_beat(hdlcenc_pkg::opcode_t'($urandom_range(3)), pick_payload());
      end
    end
    total_beats = beat_backlog.size();

    while (accepted_beats < total_beats) @(posedge clk);
    while (line_forecast.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (line_forecast.size() > 0) begin
      $display("%0t: %0d line bytes never arrived", $time, line_forecast.size());
      errors += line_forecast.size();
    end
    $display("Covered %0d input beats and %0d closed frames, %0d bytes escaped.",
             accepted_beats, frames_closed, escaped_bytes);
    $display("Checked %0d line bytes across four idling phases, %0d errors.",
             checked_bytes, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
